[rtl/core/fslt_pkg.sv]
// ----------------------------------------------------------------------------
// fslt_pkg - shared types and codes of the frame slot lifecycle tracker
// Opcodes, slot states, finalize codes and the payload structs of the
// request, result and internal command queue.
// ----------------------------------------------------------------------------
package fslt_pkg;

	localparam logic [3:0] OP_BEGIN        = 4'd0;
	localparam logic [3:0] OP_FIN_PRESENT  = 4'd1;
	localparam logic [3:0] OP_FIN_NOPRES   = 4'd2;
	localparam logic [3:0] OP_MARK_RB      = 4'd3;
	localparam logic [3:0] OP_CONSUME_RB   = 4'd4;
	localparam logic [3:0] OP_CLEAR_RB     = 4'd5;
	localparam logic [3:0] OP_COMPLETE     = 4'd6;
	localparam logic [3:0] OP_DRAIN        = 4'd7;
	localparam logic [3:0] OP_READ_LAST    = 4'd8;
	localparam logic [3:0] OP_QUERY_SLOT   = 4'd9;

	localparam logic [1:0] ST_AVAIL  = 2'd0;
	localparam logic [1:0] ST_FLIGHT = 2'd1;
	localparam logic [1:0] ST_DONE   = 2'd2;
	localparam logic [1:0] ST_FAIL   = 2'd3;

	localparam logic [1:0] FC_PRESENTED = 2'd0;
	localparam logic [1:0] FC_ALREADY   = 2'd1;
	localparam logic [1:0] FC_FAILED    = 2'd2;

	localparam logic [3:0] DRAIN_SAT = 4'd15;
	localparam int         Q_DEPTH   = 2;

	typedef struct packed {
		logic [3:0]  opcode;
		logic [7:0]  slot_index;
		logic [31:0] capture_frame_id;
		logic        success_flag;
		logic        drawable_ready;
	} fslt_in_t;

	typedef struct packed {
		logic        accepted;
		logic [1:0]  finalize_code;
		logic [3:0]  drained_count;
		logic [31:0] presented_frame_id;
		logic [2:0]  presented_slot;
		logic [31:0] current_id;
		logic        current_failed;
		logic        current_finalized;
		logic        capture_kept;
		logic        readback_flag;
		logic [1:0]  queried_state;
	} fslt_out_t;

	// classified event: slot is reduced for begin, raw index otherwise
	typedef struct packed {
		logic [3:0]  opcode;
		logic [7:0]  slot;
		logic        in_range;
		logic [31:0] cap_id;
		logic        ok;
		logic        drawable;
	} fslt_cmd_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} fslt_q_stat_t;

endpackage

[rtl/core/fslt_chan_if.sv]
// ----------------------------------------------------------------------------
// fslt_chan_if - valid/ready channel
// Carries one payload of the given type per transaction.
// ----------------------------------------------------------------------------
interface fslt_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/core/fslt_ram.sv]
// ----------------------------------------------------------------------------
// fslt_ram - generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fslt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/core/fslt_queue.sv]
// ----------------------------------------------------------------------------
// fslt_queue - short command queue between front and back end
// Register based FIFO of classified events.
// ----------------------------------------------------------------------------
module fslt_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  fslt_pkg::fslt_cmd_t  push_data,
	input  logic                 pop,
	output fslt_pkg::fslt_cmd_t  head,
	output fslt_pkg::fslt_q_stat_t stat
);
	localparam int PTR_W = (fslt_pkg::Q_DEPTH > 1) ? $clog2(fslt_pkg::Q_DEPTH) : 1;
	localparam int CNT_W = $clog2(fslt_pkg::Q_DEPTH + 1);

	fslt_pkg::fslt_cmd_t entry_q [fslt_pkg::Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full     = (count_q == CNT_W'(fslt_pkg::Q_DEPTH));
	assign stat.nonempty = (count_q != '0);
	assign do_push       = push && !stat.full;
	assign do_pop        = pop && stat.nonempty;
	assign head          = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(fslt_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(fslt_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

[rtl/core/fslt_front.sv]
// ----------------------------------------------------------------------------
// fslt_front - event intake and classification
// Takes one request, checks the slot index against the live count and, for
// begin, reduces the index modulo the count one bit per cycle.
// ----------------------------------------------------------------------------
module fslt_front #(
	parameter int SLOTS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [3:0]          slot_count,
	fslt_chan_if.sink           req,
	output logic                push,
	output fslt_pkg::fslt_cmd_t push_data,
	input  logic                q_full
);
	logic [3:0]          n_live;
	logic                hold_v_q;
	fslt_pkg::fslt_cmd_t hold_q;
	logic [3:0]          n_q;
	logic [3:0]          step_q;
	logic [3:0]          rem_q;
	logic [7:0]          dvd_q;
	logic [4:0]          trial;

	// clamp the register into 1..SLOTS
	always_comb begin
		if (slot_count == 4'd0) begin
			n_live = 4'd1;
		end else if ({28'd0, slot_count} > 32'(SLOTS)) begin
			n_live = 4'(SLOTS);
		end else begin
			n_live = slot_count;
		end
	end

	assign req.ready = !hold_v_q;
	assign trial     = {rem_q, dvd_q[7]};
	assign push      = hold_v_q && (step_q == 4'd0);

	always_comb begin
		push_data = hold_q;
		if (hold_q.opcode == fslt_pkg::OP_BEGIN) begin
			push_data.slot = {4'd0, rem_q};
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			hold_q.opcode   <= req.data.opcode;
			hold_q.slot     <= req.data.slot_index;
			hold_q.in_range <= (req.data.slot_index < {4'd0, n_live});
			hold_q.cap_id   <= req.data.capture_frame_id;
			hold_q.ok       <= req.data.success_flag;
			hold_q.drawable <= req.data.drawable_ready;
			n_q             <= n_live;
			rem_q           <= 4'd0;
			dvd_q           <= req.data.slot_index;
		end else if (hold_v_q && (step_q != 4'd0)) begin
			// restoring remainder step
			if (trial >= {1'b0, n_q}) begin
				rem_q <= 4'(trial - {1'b0, n_q});
			end else begin
				rem_q <= trial[3:0];
			end
			dvd_q <= {dvd_q[6:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			step_q   <= 4'd0;
		end else begin
			if (req.valid && req.ready) begin
				hold_v_q <= 1'b1;
				step_q   <= (req.data.opcode == fslt_pkg::OP_BEGIN) ? 4'd8 : 4'd0;
			end else if (hold_v_q && (step_q != 4'd0)) begin
				step_q <= step_q - 1'b1;
			end else if (push && !q_full) begin
				hold_v_q <= 1'b0;
			end
		end
	end
endmodule

[rtl/core/fslt_back.sv]
// ----------------------------------------------------------------------------
// fslt_back - event execution and result register
// Holds the frame and slot state, carries out one queued event at a time and
// registers its result until the receiver takes it.
// ----------------------------------------------------------------------------
module fslt_back #(
	parameter int SLOTS   = 8,
	parameter int ID_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fslt_pkg::fslt_cmd_t head,
	input  logic                q_nonempty,
	output logic                pop,
	fslt_chan_if.source         rsp
);
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [2:0] {
		B_IDLE  = 3'b001,
		B_EXEC  = 3'b010,
		B_DRAIN = 3'b100
	} b_state_t;

	b_state_t            state_q;
	fslt_pkg::fslt_cmd_t cmd_q;
	logic [1:0]          status_q [SLOTS];
	logic [ID_BITS-1:0]  cur_frame_q, next_frame_q, last_frame_q;
	logic [SLOT_W-1:0]   cur_slot_q, last_slot_q;
	logic                fin_q, fail_q, ret_q, rb_q;
	logic [SLOT_W-1:0]   drain_idx_q;
	logic [3:0]          drain_cnt_q;
	logic                out_v_q;
	fslt_pkg::fslt_out_t out_q;

	logic [ID_BITS-1:0]  slot_frame_rd;
	logic [SLOT_W-1:0]   slot_i;
	logic [ID_BITS-1:0]  next_inc;

	// next-state of one executed event
	logic [ID_BITS-1:0]  cur_n, next_n, last_n;
	logic [SLOT_W-1:0]   cslot_n, lslot_n;
	logic                fin_n, fail_n, ret_n, rb_n;
	logic                st_we;
	logic [SLOT_W-1:0]   st_addr;
	logic [1:0]          st_val;
	logic                ram_we;
	logic                acc;
	logic [1:0]          fcode;
	logic [31:0]         pid;
	logic [2:0]          pslot;
	logic [1:0]          qs;
	fslt_pkg::fslt_out_t res_exec, res_drain;
	logic [3:0]          drain_cnt_n;

	assign slot_i = cmd_q.slot[SLOT_W-1:0];
	assign pop    = (state_q == B_IDLE) && q_nonempty && !out_v_q;

	assign rsp.valid = out_v_q;
	assign rsp.data  = out_q;

	fslt_ram #(
		.WIDTH (ID_BITS),
		.DEPTH (SLOTS)
	) u_frame_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_i),
		.wdata (next_frame_q),
		.raddr (head.slot[SLOT_W-1:0]),
		.rdata (slot_frame_rd)
	);

	always_comb begin
		next_inc = next_frame_q + 1'b1;
		if (next_inc == '0) begin
			next_inc = {{(ID_BITS-1){1'b0}}, 1'b1};
		end
	end

	always_comb begin
		cur_n   = cur_frame_q;
		next_n  = next_frame_q;
		last_n  = last_frame_q;
		cslot_n = cur_slot_q;
		lslot_n = last_slot_q;
		fin_n   = fin_q;
		fail_n  = fail_q;
		ret_n   = ret_q;
		rb_n    = rb_q;
		st_we   = 1'b0;
		st_addr = slot_i;
		st_val  = fslt_pkg::ST_AVAIL;
		ram_we  = 1'b0;
		acc     = 1'b0;
		fcode   = fslt_pkg::FC_PRESENTED;
		pid     = 32'd0;
		pslot   = 3'd0;
		qs      = fslt_pkg::ST_AVAIL;
		case (cmd_q.opcode)
			fslt_pkg::OP_BEGIN: begin
				if (!((cur_frame_q != '0) && !fin_q && !fail_q)) begin
					cslot_n = slot_i;
					if (status_q[slot_i] != fslt_pkg::ST_FLIGHT) begin
						cur_n   = next_frame_q;
						next_n  = next_inc;
						fin_n   = 1'b0;
						fail_n  = 1'b0;
						ram_we  = (state_q == B_EXEC);
						st_we   = 1'b1;
						st_val  = fslt_pkg::ST_FLIGHT;
						acc     = 1'b1;
					end
				end
			end
			fslt_pkg::OP_FIN_PRESENT: begin
				if (cur_frame_q == '0) begin
					fcode = fslt_pkg::FC_FAILED;
				end else if (fin_q) begin
					fcode = fslt_pkg::FC_ALREADY;
				end else if (fail_q || !cmd_q.drawable) begin
					fail_n  = 1'b1;
					st_we   = 1'b1;
					st_addr = cur_slot_q;
					st_val  = fslt_pkg::ST_FAIL;
					fcode   = fslt_pkg::FC_FAILED;
				end else begin
					fin_n   = 1'b1;
					last_n  = cur_frame_q;
					lslot_n = cur_slot_q;
					ret_n   = 1'b1;
				end
			end
			fslt_pkg::OP_FIN_NOPRES: begin
				if (!((cur_frame_q == '0) || fin_q || fail_q)) begin
					fin_n = 1'b1;
					acc   = 1'b1;
				end
			end
			fslt_pkg::OP_MARK_RB: begin
				rb_n = 1'b1;
			end
			fslt_pkg::OP_CONSUME_RB: begin
				if (rb_q) begin
					rb_n = 1'b0;
					acc  = 1'b1;
				end
			end
			fslt_pkg::OP_CLEAR_RB: begin
				rb_n = 1'b0;
			end
			fslt_pkg::OP_COMPLETE: begin
				if (cmd_q.in_range
						&& (64'(slot_frame_rd) == 64'(cmd_q.cap_id))
						&& (status_q[slot_i] == fslt_pkg::ST_FLIGHT)
						&& !((64'(cmd_q.cap_id) == 64'(cur_frame_q)) && !fin_q)) begin
					st_we  = 1'b1;
					st_val = cmd_q.ok ? fslt_pkg::ST_DONE : fslt_pkg::ST_FAIL;
					if (!cmd_q.ok && (64'(cmd_q.cap_id) == 64'(cur_frame_q))) begin
						fail_n = 1'b1;
					end
					acc = 1'b1;
				end
			end
			fslt_pkg::OP_READ_LAST: begin
				if (ret_q && (last_frame_q != '0)) begin
					pid   = 32'(last_frame_q);
					pslot = 3'(last_slot_q);
					acc   = 1'b1;
				end
			end
			fslt_pkg::OP_QUERY_SLOT: begin
				qs = cmd_q.in_range ? status_q[slot_i] : fslt_pkg::ST_FAIL;
			end
			default: begin
			end
		endcase

		res_exec.accepted           = acc;
		res_exec.finalize_code      = fcode;
		res_exec.drained_count      = 4'd0;
		res_exec.presented_frame_id = pid;
		res_exec.presented_slot     = pslot;
		res_exec.current_id         = 32'(cur_n);
		res_exec.current_failed     = fail_n;
		res_exec.current_finalized  = fin_n;
		res_exec.capture_kept       = ret_n;
		res_exec.readback_flag      = rb_n;
		res_exec.queried_state      = qs;
	end

	// drain: count in-flight slots one per cycle, saturating
	always_comb begin
		drain_cnt_n = drain_cnt_q;
		if ((status_q[drain_idx_q] == fslt_pkg::ST_FLIGHT) && (drain_cnt_q != fslt_pkg::DRAIN_SAT)) begin
			drain_cnt_n = drain_cnt_q + 1'b1;
		end
		res_drain                = '0;
		res_drain.drained_count  = drain_cnt_n;
		res_drain.current_id     = 32'd0;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
		if (state_q == B_EXEC) begin
			out_q <= res_exec;
		end else if ((state_q == B_DRAIN) && (drain_idx_q == SLOT_W'(SLOTS - 1))) begin
			out_q <= res_drain;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			for (int i = 0; i < SLOTS; i++) begin
				status_q[i] <= fslt_pkg::ST_AVAIL;
			end
			cur_frame_q  <= '0;
			next_frame_q <= {{(ID_BITS-1){1'b0}}, 1'b1};
			last_frame_q <= '0;
			cur_slot_q   <= '0;
			last_slot_q  <= '0;
			fin_q        <= 1'b0;
			fail_q       <= 1'b0;
			ret_q        <= 1'b0;
			rb_q         <= 1'b0;
			drain_idx_q  <= '0;
			drain_cnt_q  <= 4'd0;
			out_v_q      <= 1'b0;
		end else begin
			if (out_v_q && rsp.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (pop) begin
						drain_idx_q <= '0;
						drain_cnt_q <= 4'd0;
						state_q     <= (head.opcode == fslt_pkg::OP_DRAIN) ? B_DRAIN : B_EXEC;
					end
				end
				B_EXEC: begin
					cur_frame_q  <= cur_n;
					next_frame_q <= next_n;
					last_frame_q <= last_n;
					cur_slot_q   <= cslot_n;
					last_slot_q  <= lslot_n;
					fin_q        <= fin_n;
					fail_q       <= fail_n;
					ret_q        <= ret_n;
					rb_q         <= rb_n;
					if (st_we) begin
						status_q[st_addr] <= st_val;
					end
					out_v_q <= 1'b1;
					state_q <= B_IDLE;
				end
				B_DRAIN: begin
					drain_cnt_q <= drain_cnt_n;
					if (drain_idx_q == SLOT_W'(SLOTS - 1)) begin
						for (int i = 0; i < SLOTS; i++) begin
							status_q[i] <= fslt_pkg::ST_AVAIL;
						end
						cur_frame_q  <= '0;
						fin_q        <= 1'b0;
						fail_q       <= 1'b0;
						last_frame_q <= '0;
						last_slot_q  <= '0;
						ret_q        <= 1'b0;
						rb_q         <= 1'b0;
						out_v_q      <= 1'b1;
						state_q      <= B_IDLE;
					end else begin
						drain_idx_q <= drain_idx_q + 1'b1;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end
endmodule

[rtl/core/frame_slot_lifecycle_tracker_unit.sv]
// ----------------------------------------------------------------------------
// frame_slot_lifecycle_tracker_unit - frame slot lifecycle tracker
// Tracks frames in flight over a ring of slots and answers each event with
// its status and the current frame flags.
// ----------------------------------------------------------------------------
// Usage: req carries one event per transaction (opcode, slot index, frame id
//   of a complete, success and drawable flags); rsp returns exactly one result
//   per event, in order. cfg_we/cfg_wdata write the slot count; write it only
//   while no event is outstanding.
// Flow: an event passes the intake hold register, the command queue, the
//   command register and the result register before rsp offers it; the
//   execute loop (latch, execute, hand over the result) takes the next event
//   only once the last result is taken. A begin holds the intake longer for
//   the bit-serial reduction of its slot index modulo the count. A drain
//   walks every slot once to count those in flight.
// Reset: all slots available, no current frame, next frame id 1, all flags
//   low, slot count 3; no event is held and no result is pending.
// Stall: while rsp is stalled the result register holds; the intake and the
//   two-entry command queue keep taking events until the queue fills.
// ----------------------------------------------------------------------------
module frame_slot_lifecycle_tracker_unit #(
	parameter int SLOTS   = 8,
	parameter int ID_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	fslt_chan_if.sink   req,
	fslt_chan_if.source rsp
);
	logic [3:0]             slot_count_q;
	logic                   push;
	fslt_pkg::fslt_cmd_t    push_data;
	fslt_pkg::fslt_cmd_t    head;
	fslt_pkg::fslt_q_stat_t q_stat;
	logic                   pop;

	// hold the slot count register; clamping is done at intake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= 4'd3;
		end else if (cfg_we) begin
			slot_count_q <= cfg_wdata;
		end
	end

	// intake: take a transaction, range check, reduce begin slot
	fslt_front #(
		.SLOTS (SLOTS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.slot_count (slot_count_q),
		.req        (req),
		.push       (push),
		.push_data  (push_data),
		.q_full     (q_stat.full)
	);

	// decouple intake from execution
	fslt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	// execute against the slot and frame state, register the result
	fslt_back #(
		.SLOTS   (SLOTS),
		.ID_BITS (ID_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_nonempty (q_stat.nonempty),
		.pop        (pop),
		.rsp        (rsp)
	);

`ifndef SYNTHESIS
	// execution only pulls from a non-empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_stat.nonempty)
		else $error("pop from empty command queue");

	// intake takes no second transaction in the cycle after it accepted one
	a_intake_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("intake took a second transaction while holding one");

	// a drain result reports a cleared frame state
	a_drain_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.data.drained_count != 4'd0)) |->
		((rsp.data.current_id == 32'd0) && !rsp.data.capture_kept
			&& !rsp.data.readback_flag && !rsp.data.current_finalized))
		else $error("drain result with frame state left set");
`endif
endmodule

[tb/sv/fslt_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fslt_result_checker - result predictor and scoreboard of the slot tracker
// Watches the request, response and slot count write, predicts each result
// of the tracker from its own copy of the state, and compares every field.
// ----------------------------------------------------------------------------
module fslt_result_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [3:0]          cfg_wdata,
	input  logic                req_valid,
	input  logic                req_ready,
	input  fslt_pkg::fslt_in_t  req_data,
	input  logic                rsp_valid,
	input  logic                rsp_ready,
	input  fslt_pkg::fslt_out_t rsp_data,
	output int                  fail_count,
	output int                  pending,
	output logic [31:0]         owner_view [8],
	output logic [2:0]          open_slot_view
);

	localparam int SLOT_MAX = 8;

	logic [3:0]          slot_limit;
	logic [1:0]          slot_state [SLOT_MAX];
	logic [31:0]         slot_owner [SLOT_MAX];
	logic [31:0]         open_frame;
	logic [31:0]         next_id;
	logic [2:0]          open_slot;
	logic                is_finalized;
	logic                is_failed;
	logic [31:0]         shown_frame;
	logic [2:0]          shown_slot;
	logic                shown_kept;
	logic                rb_flag;
	fslt_pkg::fslt_out_t expected_results [$];
	fslt_pkg::fslt_out_t predicted;

	assign owner_view     = slot_owner;
	assign open_slot_view = open_slot;

	task automatic report_mismatch(input string msg);
		fail_count++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
	endtask

	// Advance the tracker state by one event and return its result.
	task automatic apply_event(input fslt_pkg::fslt_in_t ev, output fslt_pkg::fslt_out_t res);
		int unsigned live;
		logic [2:0]  idx;
		logic [3:0]  flight_tally;
		res = '0;
		live = (slot_limit == 4'd0) ? 1 : (slot_limit > SLOT_MAX) ? SLOT_MAX : slot_limit;
		idx = ev.slot_index[2:0];
		flight_tally = 4'd0;
		case (ev.opcode)
			fslt_pkg::OP_BEGIN: begin
				if (open_frame == 32'd0 || is_finalized || is_failed) begin
					// the slot moves even when the begin is then refused
					open_slot = 3'(ev.slot_index % live);
					if (slot_state[open_slot] != fslt_pkg::ST_FLIGHT) begin
						open_frame = next_id;
						next_id = next_id + 32'd1;
						if (next_id == 32'd0)
							next_id = 32'd1;
						is_finalized = 1'b0;
						is_failed = 1'b0;
						slot_owner[open_slot] = open_frame;
						slot_state[open_slot] = fslt_pkg::ST_FLIGHT;
						res.accepted = 1'b1;
					end
				end
			end
			fslt_pkg::OP_FIN_PRESENT: begin
				if (open_frame == 32'd0) begin
					res.finalize_code = fslt_pkg::FC_FAILED;
				end else if (is_finalized) begin
					res.finalize_code = fslt_pkg::FC_ALREADY;
				end else if (is_failed || !ev.drawable_ready) begin
					is_failed = 1'b1;
					slot_state[open_slot] = fslt_pkg::ST_FAIL;
					res.finalize_code = fslt_pkg::FC_FAILED;
				end else begin
					is_finalized = 1'b1;
					shown_frame = open_frame;
					shown_slot = open_slot;
					shown_kept = 1'b1;
					res.finalize_code = fslt_pkg::FC_PRESENTED;
				end
			end
			fslt_pkg::OP_FIN_NOPRES: begin
				if (open_frame != 32'd0 && !is_finalized && !is_failed) begin
					is_finalized = 1'b1;
					res.accepted = 1'b1;
				end
			end
			fslt_pkg::OP_MARK_RB: rb_flag = 1'b1;
			fslt_pkg::OP_CONSUME_RB: begin
				if (rb_flag) begin
					rb_flag = 1'b0;
					res.accepted = 1'b1;
				end
			end
			fslt_pkg::OP_CLEAR_RB: rb_flag = 1'b0;
			fslt_pkg::OP_COMPLETE: begin
				// refuse a slot beyond the count, a stale id, and an open frame
				if (ev.slot_index < live && slot_owner[idx] == ev.capture_frame_id &&
						slot_state[idx] == fslt_pkg::ST_FLIGHT &&
						!(ev.capture_frame_id == open_frame && !is_finalized)) begin
					slot_state[idx] = ev.success_flag ? fslt_pkg::ST_DONE : fslt_pkg::ST_FAIL;
					if (!ev.success_flag && ev.capture_frame_id == open_frame)
						is_failed = 1'b1;
					res.accepted = 1'b1;
				end
			end
			fslt_pkg::OP_DRAIN: begin
				for (int i = 0; i < SLOT_MAX; i++) begin
					if (slot_state[i] == fslt_pkg::ST_FLIGHT &&
							flight_tally != fslt_pkg::DRAIN_SAT)
						flight_tally++;
					slot_state[i] = fslt_pkg::ST_AVAIL;
					slot_owner[i] = 32'd0;
				end
				res.drained_count = flight_tally;
				open_frame = 32'd0;
				is_finalized = 1'b0;
				is_failed = 1'b0;
				shown_frame = 32'd0;
				shown_slot = 3'd0;
				shown_kept = 1'b0;
				rb_flag = 1'b0;
			end
			fslt_pkg::OP_READ_LAST: begin
				if (shown_kept && shown_frame != 32'd0) begin
					res.presented_frame_id = shown_frame;
					res.presented_slot = shown_slot;
					res.accepted = 1'b1;
				end
			end
			fslt_pkg::OP_QUERY_SLOT:
				res.queried_state = (ev.slot_index >= live) ? fslt_pkg::ST_FAIL : slot_state[idx];
			default: ;
		endcase
		res.current_id = open_frame;
		res.current_failed = is_failed;
		res.current_finalized = is_finalized;
		res.capture_kept = shown_kept;
		res.readback_flag = rb_flag;
	endtask

	task automatic compare_result(input fslt_pkg::fslt_out_t got,
			input fslt_pkg::fslt_out_t want);
		check_field("accepted", 32'(got.accepted), 32'(want.accepted));
		check_field("finalize_code", 32'(got.finalize_code), 32'(want.finalize_code));
		check_field("drained_count", 32'(got.drained_count), 32'(want.drained_count));
		check_field("presented_frame_id", got.presented_frame_id, want.presented_frame_id);
		check_field("presented_slot", 32'(got.presented_slot), 32'(want.presented_slot));
		check_field("current_id", got.current_id, want.current_id);
		check_field("current_failed", 32'(got.current_failed), 32'(want.current_failed));
		check_field("current_finalized", 32'(got.current_finalized),
			32'(want.current_finalized));
		check_field("capture_kept", 32'(got.capture_kept), 32'(want.capture_kept));
		check_field("readback_flag", 32'(got.readback_flag), 32'(want.readback_flag));
		check_field("queried_state", 32'(got.queried_state), 32'(want.queried_state));
	endtask

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_limit = 4'd3;
			for (int i = 0; i < SLOT_MAX; i++) begin
				slot_state[i] = fslt_pkg::ST_AVAIL;
				slot_owner[i] = 32'd0;
			end
			open_frame = 32'd0;
			next_id = 32'd1;
			open_slot = 3'd0;
			is_finalized = 1'b0;
			is_failed = 1'b0;
			shown_frame = 32'd0;
			shown_slot = 3'd0;
			shown_kept = 1'b0;
			rb_flag = 1'b0;
			expected_results.delete();
			pending = 0;
		end else begin
			// retire the response first: it belongs to an older transaction
			if (rsp_valid && rsp_ready) begin
				if (expected_results.size() == 0)
					report_mismatch("result with no expectation waiting");
				else
					compare_result(rsp_data, expected_results.pop_front());
			end
			if (req_valid && req_ready) begin
				apply_event(req_data, predicted);
				expected_results.push_back(predicted);
			end
			if (cfg_we)
				slot_limit = cfg_wdata;
			pending = expected_results.size();
		end
	end

endmodule

[tb/sv/frame_slot_lifecycle_tracker_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_slot_lifecycle_tracker_unit_test - top of the slot tracker testbench
// Drives directed and random frame lifecycles through the tracker over a run
// of slot counts and idling patterns; the checker beside the block predicts
// and compares every result, and this top gives the verdict.
// ----------------------------------------------------------------------------
module frame_slot_lifecycle_tracker_unit_test;

	// opcode outside the defined set
	localparam logic [3:0] OP_UNDEFINED = 4'hF;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [3:0]  cfg_wdata;
	int          fail_count;
	int          pending;
	logic [31:0] owner_view [8];
	logic [2:0]  open_slot_view;
	int          idle_pct;
	int          stall_pct;
	int          events_sent;
	int          mode_sel;

	fslt_chan_if #(.payload_t(fslt_pkg::fslt_in_t))  req_ch ();
	fslt_chan_if #(.payload_t(fslt_pkg::fslt_out_t)) rsp_ch ();

	frame_slot_lifecycle_tracker_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	fslt_result_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.req_valid      (req_ch.valid),
		.req_ready      (req_ch.ready),
		.req_data       (req_ch.data),
		.rsp_valid      (rsp_ch.valid),
		.rsp_ready      (rsp_ch.ready),
		.rsp_data       (rsp_ch.data),
		.fail_count     (fail_count),
		.pending        (pending),
		.owner_view     (owner_view),
		.open_slot_view (open_slot_view)
	);

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Stall the result channel at the rate of the current idling pattern.
	always @(negedge clk) begin
		rsp_ch.ready = ($urandom_range(99) >= stall_pct);
	end

	// Idling patterns: none, sender idle, receiver stalling, both lightly.
	task automatic pick_mode(input int m);
		case (m)
			0: begin idle_pct = 0;  stall_pct = 0;  end
			1: begin idle_pct = 88; stall_pct = 0;  end
			2: begin idle_pct = 0;  stall_pct = 88; end
			default: begin idle_pct = 8; stall_pct = 8; end
		endcase
	endtask

	function automatic fslt_pkg::fslt_in_t make_event(input logic [3:0] op,
			input logic [7:0] slot, input logic [31:0] cap, input logic ok,
			input logic drawable);
		fslt_pkg::fslt_in_t ev;
		ev.opcode = op;
		ev.slot_index = slot;
		ev.capture_frame_id = cap;
		ev.success_flag = ok;
		ev.drawable_ready = drawable;
		return ev;
	endfunction

	// Offer one event from a falling edge and hold it until the transaction
	// completes; return at the next falling edge with valid still high.
	task automatic send_event(input fslt_pkg::fslt_in_t ev);
		while ($urandom_range(99) < idle_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.data = ev;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
		events_sent++;
	endtask

	// Drop valid and hold off until every expected result has come back.
	task automatic settle();
		req_ch.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_slot_count(input logic [3:0] value);
		settle();
		cfg_wdata = value;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Mostly well-formed lifecycles (begin, finalize, complete) with random
	// content, the rest noise over the whole field range.
	task automatic run_random(input int count);
		int          target;
		int          next_switch;
		int          roll;
		logic [2:0]  other;
		logic [7:0]  slot;
		target = events_sent + count;
		next_switch = events_sent;
		while (events_sent < target) begin
			if (events_sent >= next_switch) begin
				// step through every idling pattern in turn
				pick_mode(mode_sel);
				mode_sel = (mode_sel + 1) % 4;
				next_switch = events_sent + 40;
			end
			roll = int'($urandom_range(99));
			if (roll < 20) begin
				send_event(make_event(4'($urandom_range(15)), 8'($urandom_range(255)),
					$urandom(), 1'($urandom_range(1)), 1'($urandom_range(1))));
			end else begin
				slot = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
					: 8'($urandom_range(7));
				send_event(make_event(fslt_pkg::OP_BEGIN, slot, 32'd0, 1'b0, 1'b0));
				roll = int'($urandom_range(99));
				if (roll < 60)
					send_event(make_event(fslt_pkg::OP_FIN_PRESENT, 8'd0, 32'd0, 1'b0,
						$urandom_range(9) != 0));
				else if (roll < 90)
					send_event(make_event(fslt_pkg::OP_FIN_NOPRES, 8'd0, 32'd0, 1'b0, 1'b0));
				if ($urandom_range(99) < 30)
					send_event(make_event(fslt_pkg::OP_MARK_RB, 8'd0, 32'd0, 1'b0, 1'b0));
				if ($urandom_range(99) < 30)
					send_event(make_event(fslt_pkg::OP_READ_LAST, 8'd0, 32'd0, 1'b0, 1'b0));
				if ($urandom_range(99) < 30)
					send_event(make_event(fslt_pkg::OP_CONSUME_RB, 8'd0, 32'd0, 1'b0, 1'b0));
				if ($urandom_range(99) < 10)
					send_event(make_event(fslt_pkg::OP_CLEAR_RB, 8'd0, 32'd0, 1'b0, 1'b0));
				// free the current slot with the id it holds, sometimes too early
				if ($urandom_range(99) < 85)
					send_event(make_event(fslt_pkg::OP_COMPLETE, {5'd0, open_slot_view},
						owner_view[open_slot_view], $urandom_range(99) < 85, 1'b0));
				if ($urandom_range(1) == 0) begin
					other = 3'($urandom_range(7));
					send_event(make_event(fslt_pkg::OP_COMPLETE, {5'd0, other},
						($urandom_range(9) == 0) ? owner_view[other] + 32'd1 : owner_view[other],
						$urandom_range(99) < 80, 1'b0));
				end
				if ($urandom_range(99) < 15)
					send_event(make_event(fslt_pkg::OP_QUERY_SLOT, 8'($urandom_range(9)),
						32'd0, 1'b0, 1'b0));
				if ($urandom_range(99) < 3)
					send_event(make_event(fslt_pkg::OP_DRAIN, 8'd0, 32'd0, 1'b0, 1'b0));
			end
			// now and then hold the sender until the block has emptied
			if ($urandom_range(99) == 0)
				settle();
		end
	endtask

	localparam int PHASE_ITEMS = 115;

	initial begin
		logic [3:0] counts [8];
		counts = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd6, 4'd2, 4'd9, 4'd5};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 4'd0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		events_sent = 0;
		mode_sel = 0;
		pick_mode(0);
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part at the reset slot count of three.
		send_event(make_event(fslt_pkg::OP_QUERY_SLOT, 8'd0, 32'd0, 1'b0, 1'b0));
		send_event(make_event(fslt_pkg::OP_QUERY_SLOT, 8'd255, 32'd0, 1'b0, 1'b0));
		send_event(make_event(fslt_pkg::OP_READ_LAST, 8'd0, 32'd0, 1'b0, 1'b0));
		send_event(make_event(fslt_pkg::OP_FIN_PRESENT, 8'd0, 32'd0, 1'b0, 1'b1));
		send_event(make_event(fslt_pkg::OP_FIN_NOPRES, 8'd0, 32'd0, 1'b0, 1'b0));
		send_event(make_event(fslt_pkg::OP_CONSUME_RB, 8'd0, 32'd0, 1'b0, 1'b0));
		send_event(make_event(fslt_pkg::OP_MARK_RB, 8'd0, 32'd0, 1'b0, 1'b0));
		send_event(make_event(fslt_pkg::OP_CONSUME_RB, 8'd0, 32'd0, 1'b0, 1'b0));
		send_event(make_event(fslt_pkg::OP_CLEAR_RB, 8'd0, 32'd0, 1'b0, 1'b0));
		// begin wraps the slot index, a second begin is refused while open
		send_event(make_event(fslt_pkg::OP_BEGIN, 8'd255, 32'd0, 1'b0, 1'b0));
		send_event(make_event(fslt_pkg::OP_BEGIN, 8'd1, 32'd0, 1'b0, 1'b0));
		send_event(make_event(fslt_pkg::OP_COMPLETE, 8'd0, 32'd1, 1'b1, 1'b0));
		send_event(make_event(fslt_pkg::OP_FIN_NOPRES, 8'd0, 32'd0, 1'b0, 1'b0));
		// refused begin on a slot in flight still moves the current slot
		send_event(make_event(fslt_pkg::OP_BEGIN, 8'd3, 32'd0, 1'b0, 1'b0));
		send_event(make_event(fslt_pkg::OP_BEGIN, 8'd4, 32'd0, 1'b0, 1'b0));
		send_event(make_event(fslt_pkg::OP_FIN_PRESENT, 8'd0, 32'd0, 1'b0, 1'b0));
		send_event(make_event(fslt_pkg::OP_BEGIN, 8'd2, 32'd0, 1'b0, 1'b0));
		send_event(make_event(fslt_pkg::OP_FIN_PRESENT, 8'd0, 32'd0, 1'b0, 1'b1));
		send_event(make_event(fslt_pkg::OP_FIN_PRESENT, 8'd0, 32'd0, 1'b0, 1'b1));
		send_event(make_event(fslt_pkg::OP_READ_LAST, 8'd0, 32'd0, 1'b0, 1'b0));
		send_event(make_event(fslt_pkg::OP_COMPLETE, 8'd2, 32'd3, 1'b1, 1'b0));
		send_event(make_event(fslt_pkg::OP_COMPLETE, 8'd0, 32'd1, 1'b0, 1'b0));
		// slot beyond the count
		send_event(make_event(fslt_pkg::OP_COMPLETE, 8'd5, 32'hFFFF_FFFF, 1'b1, 1'b0));
		send_event(make_event(fslt_pkg::OP_QUERY_SLOT, 8'd2, 32'd0, 1'b0, 1'b0));
		send_event(make_event(fslt_pkg::OP_BEGIN, 8'd0, 32'd0, 1'b0, 1'b0));
		send_event(make_event(fslt_pkg::OP_DRAIN, 8'd0, 32'd0, 1'b0, 1'b0));
		send_event(make_event(OP_UNDEFINED, 8'd255, 32'hFFFF_FFFF, 1'b1, 1'b1));

		run_random(PHASE_ITEMS);
		// Walk the slot counts, the out-of-range ones among them.
		for (int p = 0; p < 8; p++) begin
			write_slot_count(counts[p]);
			run_random(PHASE_ITEMS);
		end

		settle();
		repeat (32) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
